[src/rti_pkg.sv]
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types and constants of the ray / triangle intersection unit.
// ----------------------------------------------------------------------------
package rti_pkg;

  // operand widths
  localparam int CoordW = 24;  // vertex and origin, Q12.12
  localparam int DirW   = 16;  // direction, Q1.14
  localparam int EdgeW  = 25;  // vertex differences
  localparam int PW     = 42;  // dir x e2
  localparam int QW     = 51;  // s x e1
  localparam int DetW   = 69;  // det, u, v
  localparam int NumW   = 78;  // e2 . q
  localparam int MagW   = 96;  // |num| scaled by 2^18
  localparam int QuoW   = 32;  // quotient bits produced by the divider
  localparam int DistW  = 32;  // Q16.16 distance
  localparam int CfgIdxW = 3;

  // opcodes
  localparam logic OP_TRI  = 1'b0;
  localparam logic OP_PARA = 1'b1;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DIR_Z    = 3'd5;

  // saturation limits of the distance
  localparam logic [QuoW-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [QuoW-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic signed [EdgeW-1:0] x;
    logic signed [EdgeW-1:0] y;
    logic signed [EdgeW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [DirW-1:0] x;
    logic signed [DirW-1:0] y;
    logic signed [DirW-1:0] z;
  } dir_t;

  // one classified test handed from front to back
  typedef struct packed {
    logic opcode;
    vec_t e1;
    vec_t e2;
    vec_t s;
  } work_t;

endpackage

[src/rti_if.sv]
// ----------------------------------------------------------------------------
// rti_if
// Valid/ready channels of the intersection unit: patch input, result output
// and register write.
// ----------------------------------------------------------------------------
interface rti_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [23:0] a_x;
  logic signed [23:0] a_y;
  logic signed [23:0] a_z;
  logic signed [23:0] b_x;
  logic signed [23:0] b_y;
  logic signed [23:0] b_z;
  logic signed [23:0] c_x;
  logic signed [23:0] c_y;
  logic signed [23:0] c_z;

  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                output ready);
endinterface

interface rti_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] distance;

  modport source (output valid, hit, distance, input ready);
  modport sink (input valid, hit, distance, output ready);
endinterface

interface rti_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/rti_front.sv]
// ----------------------------------------------------------------------------
// rti_front
// Accepts a patch transaction and forms the edge and origin offset vectors.
// ----------------------------------------------------------------------------
module rti_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic signed [rti_pkg::CoordW-1:0]   a_x,
  input  logic signed [rti_pkg::CoordW-1:0]   a_y,
  input  logic signed [rti_pkg::CoordW-1:0]   a_z,
  input  logic signed [rti_pkg::CoordW-1:0]   b_x,
  input  logic signed [rti_pkg::CoordW-1:0]   b_y,
  input  logic signed [rti_pkg::CoordW-1:0]   b_z,
  input  logic signed [rti_pkg::CoordW-1:0]   c_x,
  input  logic signed [rti_pkg::CoordW-1:0]   c_y,
  input  logic signed [rti_pkg::CoordW-1:0]   c_z,
  input  logic signed [rti_pkg::CoordW-1:0]   origin_x,
  input  logic signed [rti_pkg::CoordW-1:0]   origin_y,
  input  logic signed [rti_pkg::CoordW-1:0]   origin_z,
  output logic                                work_valid,
  input  logic                                work_ready,
  output rti_pkg::work_t                      work
);
  import rti_pkg::*;

  logic  f_valid_r;
  work_t f_work_r;
  logic  adv;

  // stage moves when empty or when the queue takes its content
  assign adv      = !f_valid_r || work_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (adv) begin
      f_valid_r <= in_valid;
    end
  end

  // edge vectors and origin offset
  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      f_work_r.opcode <= opcode;
      f_work_r.e1.x   <= EdgeW'(b_x) - EdgeW'(a_x);
      f_work_r.e1.y   <= EdgeW'(b_y) - EdgeW'(a_y);
      f_work_r.e1.z   <= EdgeW'(b_z) - EdgeW'(a_z);
      f_work_r.e2.x   <= EdgeW'(c_x) - EdgeW'(a_x);
      f_work_r.e2.y   <= EdgeW'(c_y) - EdgeW'(a_y);
      f_work_r.e2.z   <= EdgeW'(c_z) - EdgeW'(a_z);
      f_work_r.s.x    <= EdgeW'(origin_x) - EdgeW'(a_x);
      f_work_r.s.y    <= EdgeW'(origin_y) - EdgeW'(a_y);
      f_work_r.s.z    <= EdgeW'(origin_z) - EdgeW'(a_z);
    end
  end

  assign work_valid = f_valid_r;
  assign work       = f_work_r;

endmodule

[src/rti_queue.sv]
// ----------------------------------------------------------------------------
// rti_queue
// Small queue that decouples the front from the arithmetic back end.
// ----------------------------------------------------------------------------
module rti_queue #(
  parameter int Depth = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  rti_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rti_pkg::work_t pop_data
);
  import rti_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  work_t         mem_r [Depth];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (cnt_r != CW'(Depth));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/rti_mul.sv]
// ----------------------------------------------------------------------------
// rti_mul
// Signed multiplier split into two partial products, two register stages.
// ----------------------------------------------------------------------------
module rti_mul #(
  parameter int AW = 25,
  parameter int BW = 42
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);
  localparam int LO = BW / 2;
  localparam int HI = BW - LO;

  logic signed [AW+LO:0]   pl_r;
  logic signed [AW+HI-1:0] ph_r;
  logic signed [AW+BW-1:0] p_r;

  // partial products, then recombine
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r <= (AW+LO+1)'(a) * $signed({1'b0, b[LO-1:0]});
      ph_r <= (AW+HI)'(a) * $signed(b[BW-1:LO]);
      p_r  <= ((AW+BW)'(ph_r) <<< LO) + (AW+BW)'(pl_r);
    end
  end

  assign p = p_r;

endmodule

[src/rti_back.sv]
// ----------------------------------------------------------------------------
// rti_back
// Arithmetic back end: cross and dot products, hit test, bit-per-stage
// divider for the distance and the output register.
// ----------------------------------------------------------------------------
module rti_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              work_valid,
  output logic                              work_ready,
  input  rti_pkg::work_t                    work,
  input  rti_pkg::dir_t                     dir,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [rti_pkg::DistW-1:0]  out_distance
);
  import rti_pkg::*;

  // stage valids: 0 products, 1 cross, 2..3 dot multiply, 4 sums, 5 test,
  // then one per quotient bit
  localparam int NV = 6 + QuoW;

  logic            en;
  logic [NV-1:0]   vld_r;
  logic            out_valid_r;
  logic            out_hit_r;
  logic signed [DistW-1:0] out_dist_r;

  assign en         = !out_valid_r || out_ready;
  assign work_ready = en;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NV-2:0], work_valid};
      out_valid_r <= vld_r[NV-1];
    end
  end

  // products for the two cross products
  logic signed [PW-2:0] pa_r [6];
  logic signed [QW-2:0] qa_r [6];
  work_t                w1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= (PW-1)'(dir.y) * (PW-1)'(work.e2.z);
      pa_r[1] <= (PW-1)'(dir.z) * (PW-1)'(work.e2.y);
      pa_r[2] <= (PW-1)'(dir.z) * (PW-1)'(work.e2.x);
      pa_r[3] <= (PW-1)'(dir.x) * (PW-1)'(work.e2.z);
      pa_r[4] <= (PW-1)'(dir.x) * (PW-1)'(work.e2.y);
      pa_r[5] <= (PW-1)'(dir.y) * (PW-1)'(work.e2.x);
      qa_r[0] <= (QW-1)'(work.s.y) * (QW-1)'(work.e1.z);
      qa_r[1] <= (QW-1)'(work.s.z) * (QW-1)'(work.e1.y);
      qa_r[2] <= (QW-1)'(work.s.z) * (QW-1)'(work.e1.x);
      qa_r[3] <= (QW-1)'(work.s.x) * (QW-1)'(work.e1.z);
      qa_r[4] <= (QW-1)'(work.s.x) * (QW-1)'(work.e1.y);
      qa_r[5] <= (QW-1)'(work.s.y) * (QW-1)'(work.e1.x);
      w1_r    <= work;
    end
  end

  // p = dir x e2, q = s x e1
  logic signed [PW-1:0] p_r [3];
  logic signed [QW-1:0] q_r [3];
  work_t                w2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p_r[k] <= PW'(pa_r[2*k]) - PW'(pa_r[2*k+1]);
        q_r[k] <= QW'(qa_r[2*k]) - QW'(qa_r[2*k+1]);
      end
      w2_r <= w1_r;
    end
  end

  // dot product terms
  logic signed [EdgeW+PW-1:0] det_t [3];
  logic signed [EdgeW+PW-1:0] u_t   [3];
  logic signed [DirW+QW-1:0]  v_t   [3];
  logic signed [EdgeW+QW-1:0] num_t [3];
  logic signed [EdgeW-1:0]    e1_c  [3];
  logic signed [EdgeW-1:0]    e2_c  [3];
  logic signed [EdgeW-1:0]    s_c   [3];
  logic signed [DirW-1:0]     d_c   [3];

  assign e1_c = '{w2_r.e1.x, w2_r.e1.y, w2_r.e1.z};
  assign e2_c = '{w2_r.e2.x, w2_r.e2.y, w2_r.e2.z};
  assign s_c  = '{w2_r.s.x, w2_r.s.y, w2_r.s.z};
  assign d_c  = '{dir.x, dir.y, dir.z};

  for (genvar k = 0; k < 3; k++) begin : g_dot
    rti_mul #(.AW(EdgeW), .BW(PW)) u_det (
      .clk(clk), .en(en), .a(e1_c[k]), .b(p_r[k]), .p(det_t[k])
    );
    rti_mul #(.AW(EdgeW), .BW(PW)) u_u (
      .clk(clk), .en(en), .a(s_c[k]), .b(p_r[k]), .p(u_t[k])
    );
    rti_mul #(.AW(DirW), .BW(QW)) u_v (
      .clk(clk), .en(en), .a(d_c[k]), .b(q_r[k]), .p(v_t[k])
    );
    rti_mul #(.AW(EdgeW), .BW(QW)) u_num (
      .clk(clk), .en(en), .a(e2_c[k]), .b(q_r[k]), .p(num_t[k])
    );
  end

  // opcode follows the multiplier stages
  logic op3_r;
  logic op4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      op3_r <= w2_r.opcode;
      op4_r <= op3_r;
    end
  end

  // dot product sums
  logic signed [DetW-1:0] det_r;
  logic signed [DetW-1:0] u_r;
  logic signed [DetW-1:0] v_r;
  logic signed [NumW-1:0] num_r;
  logic                   op5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= DetW'(det_t[0]) + DetW'(det_t[1]) + DetW'(det_t[2]);
      u_r   <= DetW'(u_t[0]) + DetW'(u_t[1]) + DetW'(u_t[2]);
      v_r   <= DetW'(v_t[0]) + DetW'(v_t[1]) + DetW'(v_t[2]);
      num_r <= NumW'(num_t[0]) + NumW'(num_t[1]) + NumW'(num_t[2]);
      op5_r <= op4_r;
    end
  end

  // hit test, magnitude and overflow check
  logic                   hit_c;
  logic signed [DetW:0]   uv_c;
  logic [NumW-1:0]        abs_c;
  logic [MagW-1:0]        mag_c;
  logic                   ovf_c;
  always_comb begin
    uv_c  = (DetW+1)'(u_r) + (DetW+1)'(v_r);
    hit_c = (det_r > 0) && (u_r >= 0) && (u_r <= det_r) && (v_r >= 0) &&
            ((op5_r == OP_PARA) ? (v_r <= det_r) : (uv_c <= (DetW+1)'(det_r)));
    abs_c = num_r[NumW-1] ? NumW'(-num_r) : NumW'(num_r);
    mag_c = {abs_c, 18'd0};
    ovf_c = ({{(DetW+1-(MagW-QuoW)){1'b0}}, mag_c[MagW-1:QuoW]} >=
             {1'b0, det_r});
  end

  // divider stage registers; index 0 holds the set-up
  logic [DetW-1:0] rem_r [QuoW+1];
  logic [DetW-1:0] dv_r  [QuoW+1];
  logic [QuoW-1:0] lo_r  [QuoW+1];
  logic [QuoW-1:0] quo_r [QuoW+1];
  logic            hit_r [QuoW+1];
  logic            neg_r [QuoW+1];
  logic            ovf_r [QuoW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DetW'(mag_c[MagW-1:QuoW]);
      dv_r[0]  <= det_r;
      lo_r[0]  <= mag_c[QuoW-1:0];
      quo_r[0] <= '0;
      hit_r[0] <= hit_c;
      neg_r[0] <= num_r[NumW-1];
      ovf_r[0] <= ovf_c;
    end
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [DetW:0] trial;
    logic          take;
    assign trial = {rem_r[k], lo_r[k][QuoW-1]};
    assign take  = (trial >= {1'b0, dv_r[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= take ? DetW'(trial - {1'b0, dv_r[k]}) : DetW'(trial);
        dv_r[k+1]  <= dv_r[k];
        lo_r[k+1]  <= {lo_r[k][QuoW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][QuoW-2:0], take};
        hit_r[k+1] <= hit_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  // sign, saturation and output register
  logic signed [DistW-1:0] dist_c;
  logic [QuoW-1:0]         qf;
  always_comb begin
    qf = quo_r[QuoW];
    if (!hit_r[QuoW]) begin
      dist_c = '0;
    end else if (neg_r[QuoW]) begin
      dist_c = (ovf_r[QuoW] || qf > NEG_LIMIT) ? $signed(NEG_LIMIT) : -$signed(qf);
    end else begin
      dist_c = (ovf_r[QuoW] || qf > POS_LIMIT) ? $signed(POS_LIMIT) : $signed(qf);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r  <= hit_r[QuoW];
      out_dist_r <= dist_c;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;

endmodule

[src/ray_triangle_intersection_unit.sv]
// ----------------------------------------------------------------------------
// ray_triangle_intersection_unit
// Ray against triangle or parallelogram test with back-face culling.
// ----------------------------------------------------------------------------
// usage:
//   cfg_ch  register writes: origin x/y/z (Q12.12) and direction x/y/z
//           (Q1.14) at indexes 0..5; other indexes are ignored; always ready
//   in_ch   one transaction per patch: opcode (triangle or parallelogram)
//           and three vertices in Q12.12
//   out_ch  one transaction per patch: hit flag and distance t in Q16.16,
//           saturated, zero on a miss
// throughput: one patch per cycle sustained while the output is not stalled
// path: from input accept to output valid a patch passes the operand
//   stage, the queue, the product and sum stages and a divider
//   that resolves one quotient bit per stage (32 stages)
// reset: pipeline and queue empty, origin 0, direction (0, 0, 1)
// stall: a stalled output freezes the back end; the queue and the front
//   keep taking patches until the queue fills, then in_ch.ready drops
// registers may only be written while no patch is in flight
// ----------------------------------------------------------------------------
module ray_triangle_intersection_unit #(
  parameter int QueueDepth = 4
) (
  input logic       clk,
  input logic       rst_n,
  rti_in_if.sink    in_ch,
  rti_out_if.source out_ch,
  rti_cfg_if.sink   cfg_ch
);
  import rti_pkg::*;

  logic signed [CoordW-1:0] origin_x_r;
  logic signed [CoordW-1:0] origin_y_r;
  logic signed [CoordW-1:0] origin_z_r;
  dir_t                     dir_r;

  // register writes
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      dir_r.x    <= '0;
      dir_r.y    <= '0;
      dir_r.z    <= 16'sd16384;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_ORIGIN_X: origin_x_r <= cfg_ch.data;
        REG_ORIGIN_Y: origin_y_r <= cfg_ch.data;
        REG_ORIGIN_Z: origin_z_r <= cfg_ch.data;
        REG_DIR_X:    dir_r.x    <= cfg_ch.data[DirW-1:0];
        REG_DIR_Y:    dir_r.y    <= cfg_ch.data[DirW-1:0];
        REG_DIR_Z:    dir_r.z    <= cfg_ch.data[DirW-1:0];
        default: ;
      endcase
    end
  end

  logic  f_valid;
  logic  f_ready;
  work_t f_work;
  logic  b_valid;
  logic  b_ready;
  work_t b_work;

  rti_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .opcode(in_ch.opcode),
    .a_x(in_ch.a_x), .a_y(in_ch.a_y), .a_z(in_ch.a_z),
    .b_x(in_ch.b_x), .b_y(in_ch.b_y), .b_z(in_ch.b_z),
    .c_x(in_ch.c_x), .c_y(in_ch.c_y), .c_z(in_ch.c_z),
    .origin_x(origin_x_r), .origin_y(origin_y_r), .origin_z(origin_z_r),
    .work_valid(f_valid), .work_ready(f_ready), .work(f_work)
  );

  rti_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_work),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_work)
  );

  rti_back u_back (
    .clk(clk), .rst_n(rst_n),
    .work_valid(b_valid), .work_ready(b_ready), .work(b_work), .dir(dir_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_hit(out_ch.hit), .out_distance(out_ch.distance)
  );

endmodule

[src/rti_checker.sv]
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks of the intersection unit, bound to the top level.
// ----------------------------------------------------------------------------
module rti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [31:0] out_distance,
  input logic        cfg_ready
);

  // output channel empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a miss always reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == 32'd0)
    else $error("miss with nonzero distance");

  // register port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("register port not ready");

  // stalled result stays
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit) && $stable(out_distance))
    else $error("result changed while stalled");

endmodule

bind ray_triangle_intersection_unit rti_checker u_rti_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_hit(out_ch.hit),
  .out_distance(out_ch.distance),
  .cfg_ready(cfg_ch.ready)
);

[tb/sv/ray_triangle_intersection_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ray_triangle_intersection_unit_tb
// Self-checking bench for the ray / patch intersection unit. A queue-fed
// driver offers triangles and parallelograms, a clocked monitor predicts the
// hit flag and Q16.16 distance with exact wide arithmetic at each accepted
// transaction and checks the results in order, under several ray settings
// and several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ray_triangle_intersection_unit_tb;
  import rti_pkg::*;

  typedef struct {
    logic               op;
    logic signed [23:0] a[3];
    logic signed [23:0] b[3];
    logic signed [23:0] c[3];
  } patch_t;

  typedef struct {
    logic               hit;
    logic signed [31:0] dist_val;
  } hit_result_t;

  logic clk;
  logic rst_n;

  rti_in_if  in_ch ();
  rti_out_if out_ch ();
  rti_cfg_if cfg_ch ();

  ray_triangle_intersection_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // ray registers as the bench believes them
  logic signed [23:0] ray_origin[3];
  logic signed [15:0] ray_dir[3];

  patch_t      pending_patches[$];
  hit_result_t expected_hits[$];

  int  err_count     = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_left     = 0;
  bit  in_taken      = 0;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // exact hit test and distance for one patch against the current ray
  function automatic hit_result_t intersect_ray(input patch_t p);
    logic signed [127:0] e1[3], e2[3], s[3], d[3], pv[3], qv[3];
    logic signed [127:0] det, u, v, num, mag, quo, lim;
    hit_result_t r;
    r.hit  = 1'b0;
    r.dist_val = '0;
    for (int k = 0; k < 3; k++) begin
      d[k]  = ray_dir[k];
      e1[k] = p.b[k];
      e1[k] = e1[k] - p.a[k];
      e2[k] = p.c[k];
      e2[k] = e2[k] - p.a[k];
      s[k]  = ray_origin[k];
      s[k]  = s[k] - p.a[k];
    end
    pv[0] = d[1] * e2[2] - d[2] * e2[1];
    pv[1] = d[2] * e2[0] - d[0] * e2[2];
    pv[2] = d[0] * e2[1] - d[1] * e2[0];
    det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
    if (det <= 0) return r;
    u = s[0] * pv[0] + s[1] * pv[1] + s[2] * pv[2];
    if (u < 0 || u > det) return r;
    qv[0] = s[1] * e1[2] - s[2] * e1[1];
    qv[1] = s[2] * e1[0] - s[0] * e1[2];
    qv[2] = s[0] * e1[1] - s[1] * e1[0];
    v = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
    if (v < 0) return r;
    if (((p.op == OP_PARA) ? v : u + v) > det) return r;
    num = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
    mag = (num < 0) ? -num : num;
    mag = mag <<< 18;
    quo = mag / det;
    lim = 128'sd2147483648;
    r.hit = 1'b1;
    // truncate toward zero, then saturate to the Q16.16 range
    if (num < 0) r.dist_val = (quo > lim) ? NEG_LIMIT : 32'(-quo);
    else r.dist_val = (quo > lim - 1) ? POS_LIMIT : 32'(quo);
    return r;
  endfunction

  // register write, only while nothing is in flight
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X: ray_origin[0] = data;
      REG_ORIGIN_Y: ray_origin[1] = data;
      REG_ORIGIN_Z: ray_origin[2] = data;
      REG_DIR_X:    ray_dir[0] = data[15:0];
      REG_DIR_Y:    ray_dir[1] = data[15:0];
      REG_DIR_Z:    ray_dir[2] = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_ray(input logic [23:0] ox, oy, oz, input logic [23:0] dx, dy, dz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, dx);
    write_reg(REG_DIR_Y, dy);
    write_reg(REG_DIR_Z, dz);
  endtask

  task automatic add_patch(input logic op,
                           input int ax, ay, az, bx, by, bz, cx, cy, cz);
    patch_t p;
    p.op = op;
    p.a[0] = 24'(ax); p.a[1] = 24'(ay); p.a[2] = 24'(az);
    p.b[0] = 24'(bx); p.b[1] = 24'(by); p.b[2] = 24'(bz);
    p.c[0] = 24'(cx); p.c[1] = 24'(cy); p.c[2] = 24'(cz);
    pending_patches.push_back(p);
  endtask

  // mostly patches placed around a point on the ray, the rest pure noise
  task automatic add_random_patches(input int n);
    patch_t p;
    longint tk, pt, span;
    for (int i = 0; i < n; i++) begin
      p.op = 1'($urandom_range(1));
      if ($urandom_range(99) < 20) begin
        for (int k = 0; k < 3; k++) begin
          p.a[k] = 24'($urandom);
          p.b[k] = 24'($urandom);
          p.c[k] = 24'($urandom);
        end
      end else begin
        tk = longint'($urandom_range(1 << 21)) - (1 << 18);
        span = longint'(1) << ($urandom_range(99) < 85 ? $urandom_range(2, 14)
                                                      : $urandom_range(15, 22));
        for (int k = 0; k < 3; k++) begin
          pt = longint'(ray_origin[k]) + ((longint'(ray_dir[k]) * tk) >>> 14);
          p.a[k] = 24'(pt + longint'($urandom_range(2 * span)) - span);
          p.b[k] = 24'(pt + longint'($urandom_range(2 * span)) - span);
          p.c[k] = 24'(pt + longint'($urandom_range(2 * span)) - span);
        end
      end
      pending_patches.push_back(p);
    end
  endtask

  task automatic wait_drained();
    while (pending_patches.size() != 0 || expected_hits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 8; recv_stall_pct = 8; end
    endcase
  endtask

  // patch driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_patches.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= pending_patches[0].op;
        in_ch.a_x <= pending_patches[0].a[0];
        in_ch.a_y <= pending_patches[0].a[1];
        in_ch.a_z <= pending_patches[0].a[2];
        in_ch.b_x <= pending_patches[0].b[0];
        in_ch.b_y <= pending_patches[0].b[1];
        in_ch.b_z <= pending_patches[0].b[2];
        in_ch.c_x <= pending_patches[0].c[0];
        in_ch.c_y <= pending_patches[0].c[1];
        in_ch.c_z <= pending_patches[0].c[2];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with long hold-offs counted here
  always @(negedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_ch.ready <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  // monitor: predict on accepted patches, check accepted results
  always @(posedge clk) begin
    hit_result_t want;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_taken) expected_hits.push_back(intersect_ray(pending_patches.pop_front()));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_hits.pop_front();
        if (out_ch.hit !== want.hit)
          report_mismatch($sformatf("hit %b, expected %b", out_ch.hit, want.hit));
        if (out_ch.distance !== want.dist_val)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    out_ch.distance, want.dist_val));
      end
    end
  end

  // timeout
  initial begin
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin
    int q;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_TRI;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    ray_origin[0] = '0; ray_origin[1] = '0; ray_origin[2] = '0;
    ray_dir[0] = '0; ray_dir[1] = '0; ray_dir[2] = 16'sd16384;
    q = 4096;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset ray along +z: hit, back face, parallelogram-only,
    // behind origin, degenerate, field extremes
    add_patch(OP_TRI, -q, -q, 5 * q, -q, 3 * q, 5 * q, 3 * q, -q, 5 * q);
    add_patch(OP_PARA, -q, -q, 5 * q, -q, 3 * q, 5 * q, 3 * q, -q, 5 * q);
    add_patch(OP_TRI, -q, -q, 5 * q, 3 * q, -q, 5 * q, -q, 3 * q, 5 * q);
    add_patch(OP_TRI, -3 * q, -3 * q, q, -3 * q, q, q, q, -3 * q, q);
    add_patch(OP_PARA, -3 * q, -3 * q, q, -3 * q, q, q, q, -3 * q, q);
    add_patch(OP_TRI, -q, -q, -7 * q, -q, 3 * q, -7 * q, 3 * q, -q, -7 * q);
    add_patch(OP_PARA, -q, -q, -2 * q, -q, 3 * q, -q, 3 * q, -q, -3 * q);
    add_patch(OP_TRI, 0, 0, q, 0, 0, q, 0, 0, q);
    add_patch(OP_TRI, q, q, q, 2 * q, 2 * q, 2 * q, 3 * q, 3 * q, 3 * q);
    add_patch(OP_TRI, 0, 0, q, 0, q, q, q, 0, q);
    add_patch(OP_PARA, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, -8388608, 8388607);
    add_patch(OP_TRI, -8388608, -8388608, 8388607, -8388608, 8388607, 8388607,
              8388607, -8388608, 8388607);
    add_patch(OP_PARA, -8388608, -8388608, -8388608, -8388608, 8388607, -8388608,
              8388607, -8388608, -8388608);
    add_patch(OP_TRI, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
              8388607, 8388607, 8388607);
    add_patch(OP_TRI, -8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
              -8388608, -8388608, -8388608);
    add_random_patches(100);
    wait_drained();

    // tiny direction: distances saturate both ways
    set_ray(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd1);
    add_patch(OP_TRI, -q, -q, 8388607, -q, 3 * q, 8388607, 3 * q, -q, 8388607);
    add_patch(OP_TRI, -q, -q, -8388608, -q, 3 * q, -8388608, 3 * q, -q, -8388608);
    add_patch(OP_PARA, -q, -q, 16, -q, 3 * q, 16, 3 * q, -q, 16);
    add_random_patches(60);
    wait_drained();

    // direction cleared to zero: every patch misses
    set_ray(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    add_random_patches(30);
    wait_drained();

    // extreme registers, then random settings including beyond-unit patterns
    for (int ph = 0; ph < 8; ph++) begin
      set_idling(ph);
      case (ph)
        0: set_ray(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h004000, 24'hFFC000, 24'h004000);
        1: set_ray(24'h800000, 24'h800000, 24'h800000, 24'hFFC000, 24'h004000, 24'hFFC000);
        2: set_ray(24'h000000, 24'h000000, 24'h000000, 24'h007FFF, 24'hFF8000, 24'h000000);
        3: begin
          write_reg(3'd6, 24'($urandom));
          write_reg(3'd7, 24'($urandom));
          set_ray(24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom));
        end
        default: set_ray(24'($urandom >> 10), 24'($urandom >> 10), 24'($urandom >> 10),
                         24'($urandom_range(32768) - 16384),
                         24'($urandom_range(32768) - 16384),
                         24'($urandom_range(32768) - 16384));
      endcase
      // long receiver hold so the queue fills and input backs up
      if (ph == 2) begin
        @(posedge clk);
        hold_left = 400;
      end
      add_random_patches(45);
      // sender pauses until everything is back, then goes on
      if (ph == 5) begin
        while (expected_hits.size() != 0 || pending_patches.size() != 0) @(posedge clk);
      end
      add_random_patches(45);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
